// File: hdl/spa_pkg.sv
`default_nettype none

package spa_pkg;

	// Default pool size.
	localparam int POOL_SLOTS_DEF = 64;

	// Width of a slot index as it travels on the ports.
	localparam int SLOT_W = 6;

	// Result codes.
	typedef enum logic [2:0] {
		ST_REUSED   = 3'd0,
		ST_FRESH    = 3'd1,
		ST_FULL     = 3'd2,
		ST_FREED    = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	// Request codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_req;
		logic pop_read;
		logic commit;
		logic load_pop;
	} spa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_alloc;
		logic can_pop;
		logic out_free;
	} spa_stat_t;

endpackage

`default_nettype wire

// File: hdl/slot_pool_allocator.sv
// A request is latched, then decided; its result is loaded into the result register once
// that register is free. A reused slot from the free stack goes through the extra state
// S_POP for the stack memory read. The controller handles one request at a time, so no new
// request is taken before the last result is loaded; the result register holds until taken.
// Reset: arst_n clears the bump pointer, the stack depth and the controller at once;
// the stack memory needs no clearing.
`default_nettype none

module slot_pool_allocator
	import spa_pkg::*;
#(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              command,
	input  wire logic [SLOT_W-1:0] slot_index,
	input  wire logic              in_pool,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      granted_slot
);

	spa_cmd_t  cmd;
	spa_stat_t stat;

	// Sequencing of each request.
	spa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Pointers, free stack and result register.
	spa_dpath #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.slot_index   (slot_index),
		.in_pool      (in_pool),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.granted_slot (granted_slot)
	);

endmodule

`default_nettype wire

// File: hdl/spa_ram.sv
`default_nettype none

module spa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/spa_ctrl.sv
`default_nettype none

module spa_ctrl
	import spa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire spa_stat_t stat,
	output spa_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_POP
	} state_t;

	state_t state_q;

	// A new request is taken only while nothing is in progress.
	assign req_stall = (state_q != S_IDLE);

	// Commands follow from the state and the datapath status.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.latch_req = req_valid;
			end
			S_DECIDE: begin
				if (stat.is_alloc && stat.can_pop) begin
					cmd.pop_read = 1'b1;
				end else begin
					cmd.commit = stat.out_free;
				end
			end
			S_POP: begin
				cmd.load_pop = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (stat.is_alloc && stat.can_pop) begin
						state_q <= S_POP;
					end else if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/spa_dpath.sv
`default_nettype none

module spa_dpath
	import spa_pkg::*;
#(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spa_cmd_t          cmd,
	output spa_stat_t              stat,
	input  wire logic              command,
	input  wire logic [SLOT_W-1:0] slot_index,
	input  wire logic              in_pool,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      granted_slot
);

	localparam int PW = $clog2(POOL_SLOTS + 1);
	localparam int AW = $clog2(POOL_SLOTS);
	localparam int CW = (PW > SLOT_W) ? PW : SLOT_W;
	localparam logic [CW-1:0] POOL_C = CW'(POOL_SLOTS);

	logic              cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic              in_pool_q;
	logic [PW-1:0]     bump_q;
	logic [PW-1:0]     count_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] granted_q;

	logic [CW-1:0]     bump_w;
	logic [CW-1:0]     slot_w;
	logic [CW-1:0]     count_w;
	logic              pool_full;
	logic              ignore;
	logic              lower;
	logic              overflow;
	logic              push;
	logic [SLOT_W-1:0] ram_rdata;

	// Decision terms for the latched request.
	assign bump_w    = CW'(bump_q);
	assign slot_w    = CW'(slot_q);
	assign count_w   = CW'(count_q);
	assign pool_full = (bump_w >= POOL_C);
	assign ignore    = !in_pool_q || (slot_w >= POOL_C);
	assign lower     = (bump_q != '0) && (slot_w == bump_w - CW'(1));
	assign overflow  = (count_w >= POOL_C);
	assign push      = cmd.commit && (cmd_q == CMD_FREE) && !ignore && !lower && !overflow;

	assign stat.is_alloc = (cmd_q == CMD_ALLOC);
	assign stat.can_pop  = (count_q != '0);
	assign stat.out_free = !out_valid_q || !rsp_stall;

	// Free stack storage.
	spa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(POOL_SLOTS)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (count_q[AW-1:0]),
		.wdata (slot_q),
		.re    (cmd.pop_read),
		.raddr (AW'(count_q - PW'(1))),
		.rdata (ram_rdata)
	);

	// Latched request fields.
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			cmd_q     <= command;
			slot_q    <= slot_index;
			in_pool_q <= in_pool;
		end
	end

	// Bump pointer and stack depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop_read) begin
				count_q <= count_q - PW'(1);
			end else if (push) begin
				count_q <= count_q + PW'(1);
			end
			if (cmd.commit) begin
				if (cmd_q == CMD_ALLOC) begin
					if (!pool_full) begin
						bump_q <= bump_q + PW'(1);
					end
				end else if (!ignore && lower) begin
					bump_q <= bump_q - PW'(1);
				end
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.load_pop) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.load_pop) begin
			status_q  <= ST_REUSED;
			granted_q <= ram_rdata;
		end else if (cmd.commit) begin
			granted_q <= '0;
			if (cmd_q == CMD_ALLOC) begin
				if (pool_full) begin
					status_q <= ST_FULL;
				end else begin
					status_q  <= ST_FRESH;
					granted_q <= bump_w[SLOT_W-1:0];
				end
			end else if (ignore) begin
				status_q <= ST_IGNORED;
			end else if (lower || !overflow) begin
				status_q <= ST_FREED;
			end else begin
				status_q <= ST_OVERFLOW;
			end
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;

endmodule

`default_nettype wire
